/* src/hcc_pkg.sv */
// Shared constants for the Hack core: action, status and comp codes, address map.
package hcc_pkg;

  localparam int PROGRAM_WORDS_DEFAULT = 32768;
  localparam int DATA_WORDS_DEFAULT    = 24577;

  localparam int WORD_W = 16;

  // address map
  localparam logic [15:0] SCREEN_BASE = 16'd16384;
  localparam logic [15:0] KEYBOARD_ADDR = 16'd24576;

  // actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // run status
  localparam logic [1:0] RUN_OK      = 2'd0;
  localparam logic [1:0] RUN_HALTED  = 2'd1;
  localparam logic [1:0] RUN_BAD_ADDR = 2'd2;
  localparam logic [1:0] RUN_BAD_COMP = 2'd3;

  // comp codes, low six bits; bit 6 selects M in place of A
  localparam logic [5:0] COMP_ZERO   = 6'h2A;
  localparam logic [5:0] COMP_ONE    = 6'h3F;
  localparam logic [5:0] COMP_MONE   = 6'h3A;
  localparam logic [5:0] COMP_D      = 6'h0C;
  localparam logic [5:0] COMP_NOT_D  = 6'h0D;
  localparam logic [5:0] COMP_NEG_D  = 6'h0F;
  localparam logic [5:0] COMP_D_INC  = 6'h1F;
  localparam logic [5:0] COMP_D_DEC  = 6'h0E;
  localparam logic [5:0] COMP_X      = 6'h30;
  localparam logic [5:0] COMP_NOT_X  = 6'h31;
  localparam logic [5:0] COMP_NEG_X  = 6'h33;
  localparam logic [5:0] COMP_X_INC  = 6'h37;
  localparam logic [5:0] COMP_X_DEC  = 6'h32;
  localparam logic [5:0] COMP_D_ADD_X = 6'h02;
  localparam logic [5:0] COMP_D_SUB_X = 6'h13;
  localparam logic [5:0] COMP_X_SUB_D = 6'h07;
  localparam logic [5:0] COMP_D_AND_X = 6'h00;
  localparam logic [5:0] COMP_D_OR_X  = 6'h15;

endpackage

/* src/hack_isa_cpu_core_unit.sv */
// Hack ISA core: program store, data RAM, A/D registers, pointer and sticky status.
//
// Input channel (in_valid/in_stall) carries action, word and key_code; each
// transaction yields exactly one result transaction on the output channel
// (out_valid/out_stall): pointer, status, A, D and a screen-write report.
// Load, pointer reset and no-op go straight to the result, as does a step
// while the status is not ok or with the pointer past the store. A step that
// runs a C-instruction passes through program store read, data RAM read,
// execute/write back and output register; the two synchronous RAM reads lie
// in sequence. An A-instruction, a fetched zero word or a bad M address ends
// after the fetch. One item is in flight at a time; a new transaction is
// taken as soon as the previous one has been placed in the output register, even
// while that result still waits under out_stall. A result under stall holds.
// The keyboard word is not stored: every step rewrites it with key_code
// before any read, so a read of it returns the current key_code.
// After reset both RAMs are swept to zero, one entry a cycle, over
// max(PROGRAM_WORDS, DATA_WORDS - 1) addresses (32768 by default); in_stall is
// high during the sweep.
module hack_isa_cpu_core_unit #(
  parameter int PROGRAM_WORDS = hcc_pkg::PROGRAM_WORDS_DEFAULT,
  parameter int DATA_WORDS    = hcc_pkg::DATA_WORDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] word,
  input  logic [15:0] key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] instruction_pointer,
  output logic [1:0]  run_code,
  output logic [15:0] a_value,
  output logic [15:0] d_value,
  output logic        screen_write,
  output logic [12:0] screen_offset,
  output logic [15:0] screen_word
);

  localparam int RAM_DEPTH = DATA_WORDS - 1;  // keyboard word lives outside the RAM
  localparam int PAW = $clog2(PROGRAM_WORDS);
  localparam int DAW = $clog2(RAM_DEPTH);
  localparam int CLR_DEPTH = (PROGRAM_WORDS > RAM_DEPTH) ? PROGRAM_WORDS : RAM_DEPTH;
  localparam int CAW = $clog2(CLR_DEPTH);
  localparam logic [CAW-1:0] CLR_LAST = CAW'(CLR_DEPTH - 1);
  localparam logic [CAW:0] PROG_LIMIT_C = (CAW+1)'(PROGRAM_WORDS);
  localparam logic [CAW:0] RAM_LIMIT_C = (CAW+1)'(RAM_DEPTH);
  localparam logic [16:0] PTR_LIMIT = 17'(PROGRAM_WORDS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state;
  logic [CAW-1:0] clr_idx;

  logic [15:0] pointer;
  logic [15:0] reg_a;
  logic [15:0] reg_d;
  logic [1:0]  run_status;
  logic [15:0] key;
  logic [15:0] ins;
  logic        scr_wr;
  logic [12:0] scr_off;
  logic [15:0] scr_word;

  logic [15:0] prog_mem [PROGRAM_WORDS];
  logic [15:0] data_mem [RAM_DEPTH];
  logic [15:0] prog_rdata;
  logic [15:0] data_rdata;

  logic           prog_we;
  logic [PAW-1:0] prog_waddr;
  logic [15:0]    prog_wdata;
  logic           prog_re;
  logic           data_we;
  logic [DAW-1:0] data_waddr;
  logic [15:0]    data_wdata;
  logic           data_re;

  logic        accept;
  logic        ptr_in_range;
  logic        a_in_ram;
  logic        a_in_screen;
  logic [15:0] fetched;
  logic        fetch_bad_addr;
  logic [15:0] m_val;
  logic [15:0] alu_res;
  logic        alu_ok;
  logic        jump_hit;
  logic [15:0] scr_diff;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign ptr_in_range = {1'b0, pointer} < PTR_LIMIT;
  assign a_in_ram = reg_a < hcc_pkg::KEYBOARD_ADDR;
  assign a_in_screen = (reg_a >= hcc_pkg::SCREEN_BASE) && a_in_ram;
  assign scr_diff = reg_a - hcc_pkg::SCREEN_BASE;
  assign fetched = prog_rdata;
  // comp reads M or dest writes M, with A past the keyboard word
  assign fetch_bad_addr = (fetched[12] || fetched[3]) && (reg_a > hcc_pkg::KEYBOARD_ADDR);
  assign m_val = a_in_ram ? data_rdata : key;

  hcc_alu u_alu (
    .comp (ins[12:6]),
    .d    (reg_d),
    .a    (reg_a),
    .m    (m_val),
    .res  (alu_res),
    .ok   (alu_ok)
  );

  always_comb begin
    jump_hit = (ins[2] && alu_res[15])
            || (ins[1] && (alu_res == 16'd0))
            || (ins[0] && !alu_res[15] && (alu_res != 16'd0));
  end

  // RAM port control
  always_comb begin
    prog_we = 1'b0;
    prog_waddr = pointer[PAW-1:0];
    prog_wdata = word;
    prog_re = 1'b0;
    data_we = 1'b0;
    data_waddr = reg_a[DAW-1:0];
    data_wdata = alu_res;
    data_re = 1'b0;
    case (state)
      S_CLEAR: begin
        prog_we = {1'b0, clr_idx} < PROG_LIMIT_C;
        prog_waddr = clr_idx[PAW-1:0];
        prog_wdata = '0;
        data_we = {1'b0, clr_idx} < RAM_LIMIT_C;
        data_waddr = clr_idx[DAW-1:0];
        data_wdata = '0;
      end
      S_IDLE: begin
        prog_we = accept && (action == hcc_pkg::ACT_LOAD) && ptr_in_range;
        prog_re = accept && (action == hcc_pkg::ACT_STEP) && ptr_in_range;
      end
      S_FETCH: begin
        data_re = a_in_ram;
      end
      S_EXEC: begin
        data_we = ins[3] && a_in_ram && alu_ok;
      end
      default: begin
        prog_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[prog_waddr] <= prog_wdata;
    end
    if (prog_re) begin
      prog_rdata <= prog_mem[pointer[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (data_re) begin
      data_rdata <= data_mem[reg_a[DAW-1:0]];
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      pointer <= '0;
      reg_a <= '0;
      reg_d <= '0;
      run_status <= hcc_pkg::RUN_OK;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (action)
              hcc_pkg::ACT_LOAD: begin
                state <= S_DONE;
                pointer <= pointer + 16'd1;
              end
              hcc_pkg::ACT_STEP: begin
                if ((run_status == hcc_pkg::RUN_OK) && ptr_in_range) begin
                  state <= S_FETCH;
                end else begin
                  state <= S_DONE;
                  if (run_status == hcc_pkg::RUN_OK) begin
                    run_status <= hcc_pkg::RUN_HALTED;
                  end
                end
              end
              hcc_pkg::ACT_RESET: begin
                state <= S_DONE;
                pointer <= '0;
                run_status <= hcc_pkg::RUN_OK;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FETCH: begin
          if (fetched == 16'd0) begin
            state <= S_DONE;
            run_status <= hcc_pkg::RUN_HALTED;
          end else begin
            pointer <= pointer + 16'd1;
            if (!fetched[15]) begin
              state <= S_DONE;
              reg_a <= fetched;
            end else if (fetch_bad_addr) begin
              state <= S_DONE;
              run_status <= hcc_pkg::RUN_BAD_ADDR;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          if (!alu_ok) begin
            run_status <= hcc_pkg::RUN_BAD_COMP;
          end else begin
            if (ins[4]) begin
              reg_d <= alu_res;
            end
            if (ins[5]) begin
              reg_a <= alu_res;
            end
            // target is A from before this instruction
            if (jump_hit) begin
              pointer <= reg_a;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // per-transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= key_code;
      scr_wr <= 1'b0;
      scr_off <= '0;
      scr_word <= '0;
    end
    if (state == S_FETCH) begin
      ins <= fetched;
    end
    if ((state == S_EXEC) && alu_ok && ins[3] && a_in_screen) begin
      scr_wr <= 1'b1;
      scr_off <= scr_diff[12:0];
      scr_word <= alu_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      instruction_pointer <= pointer;
      run_code <= run_status;
      a_value <= reg_a;
      d_value <= reg_d;
      screen_write <= scr_wr;
      screen_offset <= scr_off;
      screen_word <= scr_word;
    end
  end

endmodule

/* src/hcc_alu.sv */
// Hack comp function unit: 28 comp codes, wrapping 16-bit results.
module hcc_alu (
  input  logic [6:0]  comp,
  input  logic [15:0] d,
  input  logic [15:0] a,
  input  logic [15:0] m,
  output logic [15:0] res,
  output logic        ok
);

  logic [15:0] x;
  logic        use_m;

  assign use_m = comp[6];
  assign x = use_m ? m : a;

  always_comb begin
    res = '0;
    ok = 1'b1;
    case (comp[5:0])
      hcc_pkg::COMP_ZERO: begin
        res = '0;
        ok = !use_m;
      end
      hcc_pkg::COMP_ONE: begin
        res = 16'd1;
        ok = !use_m;
      end
      hcc_pkg::COMP_MONE: begin
        res = 16'hFFFF;
        ok = !use_m;
      end
      hcc_pkg::COMP_D: begin
        res = d;
        ok = !use_m;
      end
      hcc_pkg::COMP_NOT_D: begin
        res = ~d;
        ok = !use_m;
      end
      hcc_pkg::COMP_NEG_D: begin
        res = 16'd0 - d;
        ok = !use_m;
      end
      hcc_pkg::COMP_D_INC: begin
        res = d + 16'd1;
        ok = !use_m;
      end
      hcc_pkg::COMP_D_DEC: begin
        res = d - 16'd1;
        ok = !use_m;
      end
      hcc_pkg::COMP_X:        res = x;
      hcc_pkg::COMP_NOT_X:    res = ~x;
      hcc_pkg::COMP_NEG_X:    res = 16'd0 - x;
      hcc_pkg::COMP_X_INC:    res = x + 16'd1;
      hcc_pkg::COMP_X_DEC:    res = x - 16'd1;
      hcc_pkg::COMP_D_ADD_X:  res = d + x;
      hcc_pkg::COMP_D_SUB_X:  res = d - x;
      hcc_pkg::COMP_X_SUB_D:  res = x - d;
      hcc_pkg::COMP_D_AND_X:  res = d & x;
      hcc_pkg::COMP_D_OR_X:   res = d | x;
      default: begin
        res = '0;
        ok = 1'b0;
      end
    endcase
  end

endmodule
